[design/alm_pkg.sv]
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types and codes of the array based linked list manager: command
// and status codes, field widths and the write enable group of the slot store.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int CMD_BITS    = 3;
  localparam int SLOT_BITS   = 4;
  localparam int VALUE_W     = 32;
  localparam int POS_BITS    = 5;
  localparam int STATUS_BITS = 3;

  localparam logic [CMD_BITS-1:0] CMD_INS_FRONT  = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_INS_AFTER  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_INS_BEFORE = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_DELETE     = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_READ       = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_FIND       = 3'd5;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY    = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_BADIDX   = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_ZERO     = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_UNUSED   = 3'd4;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 3'd5;
  localparam logic [STATUS_BITS-1:0] ST_NOTFOUND = 3'd6;

  // most results one find command may return
  localparam logic [POS_BITS-1:0] RESULT_LIMIT = 5'd16;

  typedef struct packed {
    logic val_we;
    logic next_we;
    logic prev_we;
  } mem_we_t;

endpackage

[design/alm_if.sv]
// ----------------------------------------------------------------------------
// alm_in_if / alm_out_if
// Valid/ready channels of the list manager: command items in, result items out.
// ----------------------------------------------------------------------------
interface alm_in_if import alm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CMD_BITS-1:0]  cmd;
  logic [SLOT_BITS-1:0] slot;
  logic [VALUE_W-1:0]   value;
  logic [POS_BITS-1:0]  position;
  logic                 all_matches;

  modport source (output valid, cmd, slot, value, position, all_matches, input ready);
  modport sink   (input valid, cmd, slot, value, position, all_matches, output ready);
endinterface

interface alm_out_if import alm_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [SLOT_BITS-1:0]   result_slot;
  logic [VALUE_W-1:0]     result_value;
  logic [POS_BITS-1:0]    result_position;
  logic                   last;

  modport source (output valid, status, result_slot, result_value, result_position, last,
                  input ready);
  modport sink   (input valid, status, result_slot, result_value, result_position, last,
                  output ready);
endinterface

[design/alm_slot_mem.sv]
// ----------------------------------------------------------------------------
// alm_slot_mem
// Slot store: value, next link and prev link arrays. One shared read address
// with registered read data, one write port per array.
// ----------------------------------------------------------------------------
module alm_slot_mem import alm_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic [$clog2(CAPACITY)-1:0]       rd_addr,
  output logic [VALUE_BITS-1:0]             rd_val,
  output logic [$clog2(CAPACITY+1)-1:0]     rd_next,
  output logic [$clog2(CAPACITY+1)-1:0]     rd_prev,
  input  mem_we_t                           we,
  input  logic [$clog2(CAPACITY)-1:0]       val_addr,
  input  logic [VALUE_BITS-1:0]             val_data,
  input  logic [$clog2(CAPACITY)-1:0]       next_addr,
  input  logic [$clog2(CAPACITY+1)-1:0]     next_data,
  input  logic [$clog2(CAPACITY)-1:0]       prev_addr,
  input  logic [$clog2(CAPACITY+1)-1:0]     prev_data
);

  localparam int LW = $clog2(CAPACITY + 1);

  logic [VALUE_BITS-1:0] val_mem  [CAPACITY];
  logic [LW-1:0]         next_mem [CAPACITY];
  logic [LW-1:0]         prev_mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (we.val_we) begin
      val_mem[val_addr] <= val_data;
    end
    if (we.next_we) begin
      next_mem[next_addr] <= next_data;
    end
    if (we.prev_we) begin
      prev_mem[prev_addr] <= prev_data;
    end
    rd_val  <= val_mem[rd_addr];
    rd_next <= next_mem[rd_addr];
    rd_prev <= prev_mem[rd_addr];
  end

endmodule

[design/array_linked_list_manager_core.sv]
// ----------------------------------------------------------------------------
// array_linked_list_manager_core
// Doubly linked list in slot memories with a free slot chain.
// ----------------------------------------------------------------------------
// Usage: command items enter on in_ch (valid/ready); each command returns one
// result item on out_ch, except find with all_matches set, which returns one
// item per match (at most 16) and marks the final one with last.
// One command is worked at a time.
// The list walk follows the next link out of the registered memory read, so
// walks go at one node per cycle unless a find is held by a stalled receiver;
// inserts take dependent link reads, then write the link memories in S_INS_W1 and S_INS_W2.
// After reset a clearing pass over all CAPACITY slots initializes the slot
// memories; in_ch.ready stays low during it.
// Results sit in an output register; a stalled receiver holds the walk of a
// find at the current node while a further match is waiting, and a new
// command is still taken while the last result of the previous one waits.
// ----------------------------------------------------------------------------
module array_linked_list_manager_core import alm_pkg::*; #(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  alm_in_if.sink     in_ch,
  alm_out_if.source  out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECIDE, S_INS_FREE, S_INS_LINK, S_INS_W1, S_INS_W2,
    S_DEL_W1, S_DEL_W2, S_WALK, S_FIND, S_EMIT
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [CMD_BITS-1:0]    cmd_r, cmd_nxt;
  logic [SLOT_BITS-1:0]   slot_r, slot_nxt;
  logic [VALUE_BITS-1:0]  val_r, val_nxt;
  logic [POS_BITS-1:0]    pos_r, pos_nxt;
  logic                   all_r, all_nxt;
  logic [LW-1:0]          fh_r, fh_nxt;
  logic [LW-1:0]          head_r, head_nxt;
  logic [LW-1:0]          tail_r, tail_nxt;
  logic [LW-1:0]          cnt_r, cnt_nxt;
  logic [LW-1:0]          fhn_r, fhn_nxt;
  logic [LW-1:0]          n_r, n_nxt;
  logic [LW-1:0]          a_r, a_nxt;
  logic                   front_r, front_nxt;
  logic [LW-1:0]          cur_r, cur_nxt;
  logic [LW-1:0]          steps_r, steps_nxt;
  logic [POS_BITS-1:0]    k_r, k_nxt;
  logic                   pend_r, pend_nxt;
  logic [POS_BITS-1:0]    pend_pos_r, pend_pos_nxt;
  logic [STATUS_BITS-1:0] res_status_r, res_status_nxt;
  logic [SLOT_BITS-1:0]   res_slot_r, res_slot_nxt;
  logic [VALUE_W-1:0]     res_value_r, res_value_nxt;
  logic [POS_BITS-1:0]    res_pos_r, res_pos_nxt;
  logic                   res_last_r, res_last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [STATUS_BITS-1:0] out_status_r, out_status_nxt;
  logic [SLOT_BITS-1:0]   out_slot_r, out_slot_nxt;
  logic [VALUE_W-1:0]     out_value_r, out_value_nxt;
  logic [POS_BITS-1:0]    out_pos_r, out_pos_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [AW-1:0]          rd_addr;
  logic [VALUE_BITS-1:0]  val_q;
  logic [LW-1:0]          nxt_q;
  logic [LW-1:0]          prv_q;
  mem_we_t                we;
  logic [AW-1:0]          val_addr, next_addr, prev_addr;
  logic [VALUE_BITS-1:0]  val_data;
  logic [LW-1:0]          next_data, prev_data;

  logic                   can_emit;
  logic                   dec_err;
  logic [STATUS_BITS-1:0] dec_code;
  logic                   match;

  alm_slot_mem #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_mem (
    .clk       (clk),
    .rd_addr   (rd_addr),
    .rd_val    (val_q),
    .rd_next   (nxt_q),
    .rd_prev   (prv_q),
    .we        (we),
    .val_addr  (val_addr),
    .val_data  (val_data),
    .next_addr (next_addr),
    .next_data (next_data),
    .prev_addr (prev_addr),
    .prev_data (prev_data)
  );

  assign can_emit = !out_valid_r || out_ch.ready;
  assign match    = (val_q == val_r);

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.result_slot     = out_slot_r;
  assign out_ch.result_value    = out_value_r;
  assign out_ch.result_position = out_pos_r;
  assign out_ch.last            = out_last_r;

  // Checks of the latched command against list state and the slot read.
  always_comb begin
    logic slot_bad, full, empty, vzero, unused;
    slot_bad = 32'(slot_r) >= 32'(CAPACITY);
    full     = (cnt_r >= NIL) || (fh_r >= NIL);
    empty    = (cnt_r == '0);
    vzero    = (val_r == '0);
    unused   = (val_q == '0);
    dec_err  = 1'b1;
    dec_code = ST_BADIDX;
    case (cmd_r)
      CMD_INS_FRONT: begin
        if (vzero) dec_code = ST_ZERO;
        else if (full) dec_code = ST_FULL;
        else dec_err = 1'b0;
      end
      CMD_INS_AFTER, CMD_INS_BEFORE: begin
        if (empty) dec_code = ST_EMPTY;
        else if (slot_bad) dec_code = ST_BADIDX;
        else if (vzero) dec_code = ST_ZERO;
        else if (unused) dec_code = ST_UNUSED;
        else if (full) dec_code = ST_FULL;
        else dec_err = 1'b0;
      end
      CMD_DELETE: begin
        if (slot_bad) dec_code = ST_BADIDX;
        else if (empty) dec_code = ST_EMPTY;
        else if (unused) dec_code = ST_UNUSED;
        else dec_err = 1'b0;
      end
      CMD_READ: begin
        if (empty) dec_code = ST_EMPTY;
        else if (pos_r == '0 || 32'(pos_r) > 32'(cnt_r)) dec_code = ST_BADIDX;
        else dec_err = 1'b0;
      end
      CMD_FIND: begin
        if (vzero) dec_code = ST_ZERO;
        else if (empty) dec_code = ST_EMPTY;
        else dec_err = 1'b0;
      end
      default: begin
        dec_code = ST_BADIDX;
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    val_nxt        = val_r;
    pos_nxt        = pos_r;
    all_nxt        = all_r;
    fh_nxt         = fh_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    fhn_nxt        = fhn_r;
    n_nxt          = n_r;
    a_nxt          = a_r;
    front_nxt      = front_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    k_nxt          = k_r;
    pend_nxt       = pend_r;
    pend_pos_nxt   = pend_pos_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_value_nxt  = res_value_r;
    res_pos_nxt    = res_pos_r;
    res_last_nxt   = res_last_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    rd_addr        = AW'(cur_r);
    we             = '0;
    val_addr       = AW'(slot_r);
    val_data       = '0;
    next_addr      = AW'(fh_r);
    next_data      = '0;
    prev_addr      = AW'(fh_r);
    prev_data      = NIL;

    case (state_r)
      S_CLEAR: begin
        we        = '{val_we: 1'b1, next_we: 1'b1, prev_we: 1'b1};
        val_addr  = clr_r;
        val_data  = '0;
        next_addr = clr_r;
        next_data = LW'(clr_r) + LW'(1);
        prev_addr = clr_r;
        prev_data = (clr_r == '0) ? NIL : LW'(clr_r) - LW'(1);
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        rd_addr = AW'(in_ch.slot);
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          slot_nxt  = in_ch.slot;
          val_nxt   = VALUE_BITS'(in_ch.value);
          pos_nxt   = in_ch.position;
          all_nxt   = in_ch.all_matches;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        res_status_nxt = ST_OK;
        res_slot_nxt   = '0;
        res_value_nxt  = '0;
        res_pos_nxt    = '0;
        res_last_nxt   = 1'b1;
        if (dec_err) begin
          res_status_nxt = dec_code;
          state_nxt      = S_EMIT;
        end else begin
          case (cmd_r)
            CMD_INS_FRONT, CMD_INS_AFTER, CMD_INS_BEFORE: begin
              rd_addr   = AW'(fh_r);
              a_nxt     = (cmd_r == CMD_INS_AFTER) ? LW'(slot_r) : prv_q;
              front_nxt = (cmd_r == CMD_INS_FRONT) ||
                          (cmd_r == CMD_INS_BEFORE && prv_q >= NIL);
              state_nxt = S_INS_FREE;
            end
            CMD_DELETE: begin
              a_nxt     = prv_q;
              n_nxt     = nxt_q;
              state_nxt = S_DEL_W1;
            end
            CMD_READ: begin
              rd_addr   = AW'(head_r);
              steps_nxt = LW'(pos_r - POS_BITS'(1));
              state_nxt = S_WALK;
            end
            default: begin
              rd_addr   = AW'(head_r);
              cur_nxt   = head_r;
              steps_nxt = '0;
              k_nxt     = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_FIND;
            end
          endcase
        end
      end
      S_INS_FREE: begin
        fhn_nxt = nxt_q;
        if (front_r) begin
          n_nxt     = head_r;
          state_nxt = S_INS_W1;
        end else begin
          rd_addr   = AW'(a_r);
          state_nxt = S_INS_LINK;
        end
      end
      S_INS_LINK: begin
        n_nxt     = nxt_q;
        state_nxt = S_INS_W1;
      end
      S_INS_W1: begin
        we        = '{val_we: 1'b1, next_we: 1'b1, prev_we: 1'b1};
        val_addr  = AW'(fh_r);
        val_data  = val_r;
        next_addr = AW'(fh_r);
        next_data = n_r;
        prev_addr = AW'(fh_r);
        prev_data = front_r ? NIL : a_r;
        state_nxt = S_INS_W2;
      end
      S_INS_W2: begin
        if (!front_r) begin
          we.next_we = 1'b1;
          next_addr  = AW'(a_r);
          next_data  = fh_r;
        end else begin
          head_nxt = fh_r;
        end
        if (n_r < NIL) begin
          we.prev_we = 1'b1;
          prev_addr  = AW'(n_r);
          prev_data  = fh_r;
        end else begin
          tail_nxt = fh_r;
        end
        fh_nxt       = fhn_r;
        cnt_nxt      = cnt_r + LW'(1);
        res_slot_nxt = SLOT_BITS'(fh_r);
        state_nxt    = S_EMIT;
      end
      S_DEL_W1: begin
        if (a_r < NIL) begin
          we.next_we = 1'b1;
          next_addr  = AW'(a_r);
          next_data  = n_r;
        end else begin
          head_nxt = n_r;
        end
        if (n_r < NIL) begin
          we.prev_we = 1'b1;
          prev_addr  = AW'(n_r);
          prev_data  = a_r;
        end else begin
          tail_nxt = a_r;
        end
        we.val_we = 1'b1;
        val_addr  = AW'(slot_r);
        val_data  = '0;
        state_nxt = S_DEL_W2;
      end
      S_DEL_W2: begin
        we.next_we = 1'b1;
        we.prev_we = 1'b1;
        next_addr  = AW'(slot_r);
        next_data  = fh_r;
        prev_addr  = AW'(slot_r);
        prev_data  = NIL;
        fh_nxt     = LW'(slot_r);
        cnt_nxt    = cnt_r - LW'(1);
        state_nxt  = S_EMIT;
      end
      S_WALK: begin
        if (steps_r == '0) begin
          res_value_nxt = VALUE_W'(val_q);
          state_nxt     = S_EMIT;
        end else begin
          rd_addr   = AW'(nxt_q);
          steps_nxt = steps_r - LW'(1);
        end
      end
      S_FIND: begin
        if (cur_r >= NIL || steps_r >= NIL) begin
          // walk done: flush the held match as the final item, or report not found
          if (pend_r) begin
            res_pos_nxt = pend_pos_r;
          end else begin
            res_status_nxt = ST_NOTFOUND;
          end
          state_nxt = S_EMIT;
        end else if (match && !all_r) begin
          res_pos_nxt = POS_BITS'(steps_r) + POS_BITS'(1);
          state_nxt   = S_EMIT;
        end else if (match && pend_r && !can_emit) begin
          // hold at this node until the output frees
          rd_addr = AW'(cur_r);
        end else begin
          if (match) begin
            if (pend_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OK;
              out_slot_nxt   = '0;
              out_value_nxt  = '0;
              out_pos_nxt    = pend_pos_r;
              out_last_nxt   = 1'b0;
            end
            pend_nxt     = 1'b1;
            pend_pos_nxt = POS_BITS'(steps_r) + POS_BITS'(1);
            k_nxt        = k_r + POS_BITS'(1);
          end
          if (match && k_r == RESULT_LIMIT - POS_BITS'(1)) begin
            res_pos_nxt = POS_BITS'(steps_r) + POS_BITS'(1);
            state_nxt   = S_EMIT;
          end else begin
            rd_addr   = AW'(nxt_q);
            cur_nxt   = nxt_q;
            steps_nxt = steps_r + LW'(1);
          end
        end
      end
      S_EMIT: begin
        if (can_emit) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_value_nxt  = res_value_r;
          out_pos_nxt    = res_pos_r;
          out_last_nxt   = res_last_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      fh_r        <= '0;
      head_r      <= NIL;
      tail_r      <= NIL;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      fh_r        <= fh_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    val_r        <= val_nxt;
    pos_r        <= pos_nxt;
    all_r        <= all_nxt;
    fhn_r        <= fhn_nxt;
    n_r          <= n_nxt;
    a_r          <= a_nxt;
    front_r      <= front_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    k_r          <= k_nxt;
    pend_pos_r   <= pend_pos_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_value_r  <= res_value_nxt;
    res_pos_r    <= res_pos_nxt;
    res_last_r   <= res_last_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
